/* src/vector_move_towards_macros.svh */
// Assertion helpers used by the top-level RTL.
`ifndef VECTOR_MOVE_TOWARDS_MACROS_SVH
`define VECTOR_MOVE_TOWARDS_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define VMT_ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define VMT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* src/vmt_pkg.sv */
package vmt_pkg;

   // Number of coordinate axes handled side by side.
   localparam int AXES = 3;

   typedef logic [AXES-1:0] axis_mask_type;

endpackage

/* src/vmt_front.sv */
module vmt_front import vmt_pkg::*; #(
   parameter int W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [W-1:0]  from_i [AXES],
   input  logic signed [W-1:0]  to_i [AXES],
   input  logic [W-2:0]         step_i,
   output logic                 out_valid,
   output logic [2*W+1:0]       dist_sq_o,
   output logic                 reached_o,
   output logic [2*W-1:0]       prod_o [AXES],
   output logic signed [W-1:0]  from_o [AXES],
   output logic signed [W-1:0]  to_o [AXES],
   output axis_mask_type        neg_o
);

   localparam int DW = 2 * W + 2;

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [W-1:0] from1_ff [AXES], from2_ff [AXES], from3_ff [AXES], from4_ff [AXES];
   logic signed [W-1:0] to1_ff [AXES], to2_ff [AXES], to3_ff [AXES], to4_ff [AXES];
   axis_mask_type       neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [W:0]          mag1_ff [AXES];
   logic [W-2:0]        step1_ff;
   logic [DW-1:0]       sq2_ff [AXES];
   logic [2*W-3:0]      ss2_ff, ss3_ff;
   logic [2*W-1:0]      p2_ff [AXES], p3_ff [AXES], p4_ff [AXES];
   logic [DW-1:0]       d3_ff, d4_ff;
   logic                reached4_ff;

   logic signed [W:0]   diff_in [AXES];
   logic [W:0]          mag_in [AXES];

   // Form per-axis difference and magnitude.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         diff_in[i] = $signed({to_i[i][W-1], to_i[i]}) - $signed({from_i[i][W-1], from_i[i]});
         mag_in[i]  = diff_in[i][W] ? (W+1)'(-diff_in[i]) : (W+1)'(diff_in[i]);
      end
   end

   // Advance all stages together; valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 1: differences.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            from1_ff[i] <= from_i[i];
            to1_ff[i]   <= to_i[i];
            mag1_ff[i]  <= mag_in[i];
            neg1_ff[i]  <= diff_in[i][W];
         end
         step1_ff <= step_i;
      end
   end

   // Stage 2: squares and step products.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            sq2_ff[i]   <= DW'(mag1_ff[i]) * DW'(mag1_ff[i]);
            p2_ff[i]    <= (2*W)'(mag1_ff[i]) * (2*W)'(step1_ff);
            from2_ff[i] <= from1_ff[i];
            to2_ff[i]   <= to1_ff[i];
         end
         ss2_ff  <= (2*W-2)'(step1_ff) * (2*W-2)'(step1_ff);
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: squared distance.
   always_ff @(posedge clock) begin
      if (en) begin
         d3_ff  <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
         ss3_ff <= ss2_ff;
         for (int i = 0; i < AXES; i++) begin
            p3_ff[i]    <= p2_ff[i];
            from3_ff[i] <= from2_ff[i];
            to3_ff[i]   <= to2_ff[i];
         end
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: reached when inside the step, or when already at the target.
   always_ff @(posedge clock) begin
      if (en) begin
         d4_ff       <= d3_ff;
         reached4_ff <= (d3_ff < DW'(ss3_ff)) || (d3_ff == '0);
         for (int i = 0; i < AXES; i++) begin
            p4_ff[i]    <= p3_ff[i];
            from4_ff[i] <= from3_ff[i];
            to4_ff[i]   <= to3_ff[i];
         end
         neg4_ff <= neg3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign dist_sq_o = d4_ff;
   assign reached_o = reached4_ff;
   assign prod_o    = p4_ff;
   assign from_o    = from4_ff;
   assign to_o      = to4_ff;
   assign neg_o     = neg4_ff;

endmodule

/* src/vmt_sqrt.sv */
module vmt_sqrt import vmt_pkg::*; #(
   parameter int W  = 24,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*W+1:0]  dist_sq_i,
   input  logic [SW-1:0]   side_i,
   output logic            out_valid,
   output logic [W:0]      root_o,
   output logic [SW-1:0]   side_o
);

   localparam int DW = 2 * W + 2;
   localparam int RW = W + 4;
   localparam int N  = W + 1;

   logic [RW-1:0] rem_ff  [N];
   logic [W:0]    root_ff [N];
   logic [DW-1:0] dd_ff   [N];
   logic [SW-1:0] side_ff [N];
   logic          v_ff    [N];

   // One root bit per stage, two radicand bits consumed each time.
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [RW-1:0] rem_prev, rem_cat, trial, rem_in;
      logic [W:0]    root_prev, root_in;
      logic [DW-1:0] dd_prev, dd_in;
      logic [SW-1:0] side_prev;
      logic          v_prev, ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign dd_prev   = dist_sq_i;
         assign side_prev = side_i;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign dd_prev   = dd_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign v_prev    = v_ff[k-1];
      end

      always_comb begin
         rem_cat = {rem_prev[RW-3:0], dd_prev[DW-1 -: 2]};
         trial   = RW'({root_prev, 2'b01});
         ge      = rem_cat >= trial;
         rem_in  = ge ? rem_cat - trial : rem_cat;
         root_in = {root_prev[W-1:0], ge};
         dd_in   = {dd_prev[DW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            dd_ff[k]   <= dd_in;
            side_ff[k] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign root_o    = root_ff[N-1];
   assign side_o    = side_ff[N-1];

endmodule

/* src/vmt_div.sv */
module vmt_div import vmt_pkg::*; #(
   parameter int W  = 24,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*W-1:0]  prod_i [AXES],
   input  logic [W:0]      div_i,
   input  logic [SW-1:0]   side_i,
   output logic            out_valid,
   output logic [W:0]      quot_o [AXES],
   output logic [W+1:0]    rem_o [AXES],
   output logic [W:0]      div_o,
   output logic [SW-1:0]   side_o
);

   localparam int PW = W + 2;
   localparam int N  = W + 1;

   logic [PW-1:0] prem_ff [N][AXES];
   logic [W:0]    low_ff  [N][AXES];
   logic [W:0]    quot_ff [N][AXES];
   logic [W:0]    div_ff  [N];
   logic [SW-1:0] side_ff [N];
   logic          v_ff    [N];

   // One quotient bit per stage on all three lanes, shared divisor.
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [PW-1:0] prem_prev [AXES];
      logic [PW-1:0] cat [AXES];
      logic [PW-1:0] prem_in [AXES];
      logic [W:0]    low_prev [AXES];
      logic [W:0]    quot_prev [AXES];
      logic [W:0]    div_prev;
      logic [SW-1:0] side_prev;
      logic          v_prev;
      axis_mask_type ge;

      if (k == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < AXES; i++) begin
               prem_prev[i] = PW'(prod_i[i][2*W-1:W+1]);
               low_prev[i]  = prod_i[i][W:0];
               quot_prev[i] = '0;
            end
         end
         assign div_prev  = div_i;
         assign side_prev = side_i;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign prem_prev = prem_ff[k-1];
         assign low_prev  = low_ff[k-1];
         assign quot_prev = quot_ff[k-1];
         assign div_prev  = div_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign v_prev    = v_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < AXES; i++) begin
            cat[i]     = {prem_prev[i][PW-2:0], low_prev[i][W]};
            ge[i]      = cat[i] >= PW'(div_prev);
            prem_in[i] = ge[i] ? cat[i] - PW'(div_prev) : cat[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < AXES; i++) begin
               prem_ff[k][i] <= prem_in[i];
               low_ff[k][i]  <= {low_prev[i][W-1:0], 1'b0};
               quot_ff[k][i] <= {quot_prev[i][W-1:0], ge[i]};
            end
            div_ff[k]  <= div_prev;
            side_ff[k] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign quot_o    = quot_ff[N-1];
   assign rem_o     = prem_ff[N-1];
   assign div_o     = div_ff[N-1];
   assign side_o    = side_ff[N-1];

endmodule

/* src/vector_move_towards.sv */
// Moves a point towards a target by at most max_step, all in signed Q12.12.
// One request is taken every cycle while no result is stalled, and results come back
// in order: the front stages form the differences, squares and the reached test, the
// integer square root of the squared distance takes one stage per root bit
// (COORD_WIDTH + 1), the three per-axis divisions by that root share a pipeline of
// one stage per quotient bit (COORD_WIDTH + 1), and the output register stage rounds
// and steps. A stalled result holds the whole pipeline, so req_ready falls only
// while rsp_valid waits.
`include "vector_move_towards_macros.svh"

module vector_move_towards import vmt_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_from_x,
   input  logic signed [COORD_WIDTH-1:0] req_from_y,
   input  logic signed [COORD_WIDTH-1:0] req_from_z,
   input  logic signed [COORD_WIDTH-1:0] req_to_x,
   input  logic signed [COORD_WIDTH-1:0] req_to_y,
   input  logic signed [COORD_WIDTH-1:0] req_to_z,
   input  logic [COORD_WIDTH-2:0]        req_max_step,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_reached
);

   localparam int W   = COORD_WIDTH;
   localparam int DSW = 2 * AXES * W + AXES + 1;
   localparam int SSW = AXES * 2 * W + DSW;

   logic                en;
   logic signed [W-1:0] from_in [AXES];
   logic signed [W-1:0] to_in [AXES];

   logic                f_valid, f_reached;
   logic [2*W+1:0]      f_dist_sq;
   logic [2*W-1:0]      f_prod [AXES];
   logic signed [W-1:0] f_from [AXES];
   logic signed [W-1:0] f_to [AXES];
   axis_mask_type       f_neg;

   logic [SSW-1:0]      s_side_in, s_side_out;
   logic                s_valid;
   logic [W:0]          s_root;
   logic [2*W-1:0]      s_prod [AXES];

   logic [DSW-1:0]      d_side_out;
   logic                d_valid;
   logic [W:0]          d_quot [AXES];
   logic [W+1:0]        d_rem [AXES];
   logic [W:0]          d_div;
   logic signed [W-1:0] d_from [AXES];
   logic signed [W-1:0] d_to [AXES];
   axis_mask_type       d_neg;
   logic                d_reached;

   logic [W+1:0]        q_round [AXES];
   logic signed [W-1:0] res_in [AXES];
   axis_mask_type       q_fit;

   logic                out_valid_ff, reached_ff;
   logic signed [W-1:0] out_ff [AXES];

   // Advance the pipeline unless a finished result is waiting.
   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   assign from_in = '{req_from_x, req_from_y, req_from_z};
   assign to_in   = '{req_to_x, req_to_y, req_to_z};

   vmt_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .from_i    (from_in),
      .to_i      (to_in),
      .step_i    (req_max_step),
      .out_valid (f_valid),
      .dist_sq_o (f_dist_sq),
      .reached_o (f_reached),
      .prod_o    (f_prod),
      .from_o    (f_from),
      .to_o      (f_to),
      .neg_o     (f_neg)
   );

   // Pack the data that rides alongside the root computation.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         s_side_in[DSW + i*2*W +: 2*W]   = f_prod[i];
         s_side_in[AXES*W + 1 + AXES + i*W +: W] = f_from[i];
         s_side_in[1 + AXES + i*W +: W]  = f_to[i];
      end
      s_side_in[1 +: AXES] = f_neg;
      s_side_in[0]         = f_reached;
   end

   vmt_sqrt #(.W(W), .SW(SSW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .dist_sq_i (f_dist_sq),
      .side_i    (s_side_in),
      .out_valid (s_valid),
      .root_o    (s_root),
      .side_o    (s_side_out)
   );

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         s_prod[i] = s_side_out[DSW + i*2*W +: 2*W];
      end
   end

   vmt_div #(.W(W), .SW(DSW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .prod_i    (s_prod),
      .div_i     (s_root),
      .side_i    (s_side_out[DSW-1:0]),
      .out_valid (d_valid),
      .quot_o    (d_quot),
      .rem_o     (d_rem),
      .div_o     (d_div),
      .side_o    (d_side_out)
   );

   // Unpack, round half away from zero, and step towards the target.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         d_from[i]  = d_side_out[AXES*W + 1 + AXES + i*W +: W];
         d_to[i]    = d_side_out[1 + AXES + i*W +: W];
         q_round[i] = (W+2)'(d_quot[i])
                    + (W+2)'(({d_rem[i], 1'b0} >= (W+3)'(d_div)) ? 1'b1 : 1'b0);
         res_in[i]  = d_neg[i] ? d_from[i] - $signed(q_round[i][W-1:0])
                               : d_from[i] + $signed(q_round[i][W-1:0]);
         q_fit[i]   = !q_round[i][W+1] && (!q_round[i][W] || (q_round[i][W-1:0] == '0));
      end
      d_neg     = d_side_out[1 +: AXES];
      d_reached = d_side_out[0];
   end

   // Hold the result until the transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            out_ff[i] <= d_reached ? d_to[i] : res_in[i];
         end
         reached_ff <= d_reached;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_out_x   = out_ff[0];
   assign rsp_out_y   = out_ff[1];
   assign rsp_out_z   = out_ff[2];
   assign rsp_reached = reached_ff;

   `VMT_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready,
      !req_ready, "request taken while result stalled")
   `VMT_ASSERT_IMPLY(a_quot_bound, clock, reset, d_valid && !d_reached,
      q_fit == '1, "rounded step exceeds axis distance")
   `VMT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(reached_ff), "stalled result changed")

endmodule

/* tb/tb_vector_move_towards.sv */
module tb_vector_move_towards;
   import vmt_pkg::*;

   localparam int CW = 24;
   localparam int N_RANDOM = 1930;
   localparam int DRAIN_AT = 900;
   localparam int LONG_STALL_AT = 300;
   localparam int LONG_STALL_LEN = 250;
   localparam int LATENCY = 2 * CW + 7;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [CW-2:0] step_type;

   typedef struct {
      coord_type fx, fy, fz, tx, ty, tz;
      step_type  step;
   } move_req_type;

   typedef struct {
      coord_type ox, oy, oz;
      logic      reached;
   } move_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_from_x = '0, req_from_y = '0, req_from_z = '0;
   coord_type req_to_x = '0, req_to_y = '0, req_to_z = '0;
   step_type  req_max_step = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   coord_type rsp_out_x, rsp_out_y, rsp_out_z;
   logic      rsp_reached;

   move_req_type pending_q[$];
   move_rsp_type expected_moves[$];
   move_req_type cur_req;
   int n_errors = 0;
   int n_sent = 0;
   int n_popped = 0;
   int n_rsp = 0;
   int n_reached = 0;
   bit stim_done = 0;

   vector_move_towards #(.COORD_WIDTH(CW)) dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // integer square root of a squared distance
   function automatic logic [63:0] int_sqrt(logic [63:0] dsq);
      logic [127:0] c;
      logic [63:0] r;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = {64'd0, r | (64'd1 << b)};
         if (c * c <= {64'd0, dsq}) r = c[63:0];
      end
      return r;
   endfunction

   function automatic move_rsp_type predict_move(move_req_type m);
      move_rsp_type res;
      logic signed [CW:0] d[3];
      logic [63:0] mag[3];
      logic [63:0] dsq, stp, r, p, q, rm;
      coord_type fr[3], tg[3], o[3];
      fr = '{m.fx, m.fy, m.fz};
      tg = '{m.tx, m.ty, m.tz};
      dsq = '0;
      stp = {41'd0, m.step};
      for (int i = 0; i < 3; i++) begin
         d[i] = {tg[i][CW-1], tg[i]} - {fr[i][CW-1], fr[i]};
         mag[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
         dsq += mag[i] * mag[i];
      end
      if (dsq < stp * stp || (stp == 0 && dsq == 0)) begin
         res = '{tg[0], tg[1], tg[2], 1'b1};
      end else begin
         r = int_sqrt(dsq);
         for (int i = 0; i < 3; i++) begin
            p = mag[i] * stp;
            q = p / r;
            rm = p % r;
            if (2 * rm >= r) q++;
            o[i] = d[i] < 0 ? fr[i] - coord_type'(q) : fr[i] + coord_type'(q);
         end
         res = '{o[0], o[1], o[2], 1'b0};
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR result %0d: %s got %0d expected %0d", n_rsp, what, got, want);
      n_errors++;
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
         1: return coord_type'($signed($urandom_range(0, 400)) - 200);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic add_move(coord_type fx, fy, fz, tx, ty, tz, step_type s);
      move_req_type m;
      m = '{fx, fy, fz, tx, ty, tz, s};
      pending_q.push_back(m);
   endtask

   // directed cases, then random moves
   initial begin
      move_req_type m;
      coord_type b, k;
      int dd;
      add_move(0, 0, 0, 0, 0, 0, 0);
      add_move(5, -7, 9, 5, -7, 9, 0);
      add_move(5, -7, 9, 5, -7, 9, 23'h7fffff);
      add_move(0, 0, 0, 3, 4, 0, 5);
      add_move(0, 0, 0, 3, 4, 0, 6);
      add_move(0, 0, 0, 3, 4, 0, 4);
      add_move(100, 100, 100, 100 - 3000, 100 + 4000, 100, 5000);
      add_move(24'sh800000, 24'sh800000, 24'sh800000,
               24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h7fffff);
      add_move(24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
               24'sh800000, 24'sh800000, 24'sh800000, 23'h7fffff);
      add_move(24'sh7fffff, 24'sh800000, 24'sh7fffff,
               24'sh800000, 24'sh7fffff, 24'sh800000, 1);
      add_move(24'sh800000, 0, 0, 24'sh7fffff, 0, 0, 23'h7fffff);
      add_move(0, 0, 0, 1, 0, 0, 0);
      add_move(0, 0, 0, 1, 1, 1, 1);
      add_move(0, 0, 0, -1, -1, -1, 1);
      add_move(0, 0, 0, 1, 1, 0, 1);
      add_move(0, 0, 0, 4096, 0, 0, 2048);
      add_move(0, 0, 0, -4096, 4096, -4096, 2048);
      add_move(0, 0, 0, 2, 0, 0, 1);
      add_move(0, 0, 0, -3, 0, 0, 2);
      add_move(-1, -1, -1, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h400000);
      for (int n = 0; n < N_RANDOM; n++) begin
         case ($urandom_range(0, 3))
            0: begin
               m = '{rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), step_type'($urandom)};
            end
            1: begin
               // target close to start, step around the distance
               m.fx = coord_type'($urandom); m.fy = coord_type'($urandom);
               m.fz = coord_type'($urandom);
               dd = $urandom_range(1, 20000);
               m.tx = m.fx + coord_type'($signed($urandom_range(0, 2 * dd)) - dd);
               m.ty = m.fy + coord_type'($signed($urandom_range(0, 2 * dd)) - dd);
               m.tz = m.fz + coord_type'($signed($urandom_range(0, 2 * dd)) - dd);
               m.step = step_type'($urandom_range(0, 2 * dd));
            end
            2: begin
               // Pythagorean quadruple, step at the exact distance +-1
               b = coord_type'($signed($urandom_range(0, 4000)) - 2000);
               k = coord_type'($urandom_range(1, 600));
               m = '{b, b, b, b + 2 * k, b + 3 * k, b + 6 * k,
                     step_type'(7 * k + $signed($urandom_range(0, 2)) - 1)};
            end
            default: begin
               m = '{coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                     step_type'($urandom)};
            end
         endcase
         pending_q.push_back(m);
      end
      stim_done = 1;
   end

   // driver: bursts and gaps, one pause until the pipeline drains
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_moves.push_back(predict_move(cur_req));
            n_sent++;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (n_popped == DRAIN_AT && expected_moves.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               cur_req = pending_q.pop_front();
               n_popped++;
               req_from_x <= cur_req.fx; req_from_y <= cur_req.fy;
               req_from_z <= cur_req.fz; req_to_x <= cur_req.tx;
               req_to_y <= cur_req.ty; req_to_z <= cur_req.tz;
               req_max_step <= cur_req.step;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 80);
                  gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // receiver: changing stall pattern plus one long hold-off
   int mode_left = 0;
   int ready_mode = 0;
   int long_left = 0;
   bit long_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!long_done && n_sent >= LONG_STALL_AT) begin
            long_done = 1;
            long_left = LONG_STALL_LEN;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 120);
            ready_mode = $urandom_range(0, 3);
         end
         mode_left--;
         if (long_left > 0) begin
            long_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               2: rsp_ready <= $urandom_range(0, 4) != 0;
               default: rsp_ready <= $urandom_range(0, 4) == 0;
            endcase
         end
      end
   end

   // monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      move_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_moves.size() == 0) begin
            $display("ERROR result %0d: unexpected transfer", n_rsp);
            n_errors++;
         end else begin
            want = expected_moves.pop_front();
            if (rsp_out_x !== want.ox) report_mismatch("out_x", rsp_out_x, want.ox);
            if (rsp_out_y !== want.oy) report_mismatch("out_y", rsp_out_y, want.oy);
            if (rsp_out_z !== want.oz) report_mismatch("out_z", rsp_out_z, want.oz);
            if (rsp_reached !== want.reached)
               report_mismatch("reached", rsp_reached, want.reached);
            if (want.reached) n_reached++;
         end
         n_rsp++;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (pending_q.size() != 0 || req_valid || expected_moves.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (expected_moves.size() != 0) begin
         $display("ERROR %0d results never arrived", expected_moves.size());
         n_errors++;
      end
      $display("Sent %0d move requests, checked %0d results (%0d reached target)",
               n_sent, n_rsp, n_reached);
      $display("Covered extremes, exact-distance ties, zero steps and a drained pause");
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("ERROR timeout");
      $display("Mismatches found");
      $finish;
   end

endmodule
